@@ hdl/mt19937_pkg.sv @@
// Shared constants, types and tempering/twist functions for the MT19937 stream generator.
// No dependencies; the core, the result queue and the top level import this package.
package mt19937_pkg;

    // Field layout of the input item.
    localparam int IDX_W      = 10;
    localparam int WORD_W     = 32;
    localparam int IDX_LSB    = 0;
    localparam int WORD_LSB   = IDX_LSB + IDX_W;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 32;

    // Recurrence and tempering constants.
    localparam int            TWIST_OFFSET  = 397;
    localparam logic [31:0]   TEMPER_MASK_B = 32'h9D2C_5680;
    localparam logic [31:0]   TEMPER_MASK_C = 32'hEFC6_0000;
    localparam logic [31:0]   TWIST_MATRIX  = 32'h9908_B0DF;
    localparam logic [31:0]   HIGH_BIT_MASK = 32'h8000_0000;
    localparam logic [31:0]   LOW_BITS_MASK = 32'h7FFF_FFFF;

    // Result queue sizing.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    // Meaning of the tuser bit on the input side.
    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_GEN  = 1'b1
    } mode_t;

    // Output tempering of one state word.
    function automatic logic [31:0] temper_word(input logic [31:0] v);
        logic [31:0] t;
        t = v;
        t = t ^ (t >> 11);
        t = t ^ ((t << 7) & TEMPER_MASK_B);
        t = t ^ ((t << 15) & TEMPER_MASK_C);
        t = t ^ (t >> 18);
        return t;
    endfunction

    // Twist of the current word with the next one.
    function automatic logic [31:0] twist_word(input logic [31:0] cur, input logic [31:0] nxt);
        logic [31:0] mixed;
        logic [31:0] mag;
        mixed = (cur & HIGH_BIT_MASK) | (nxt & LOW_BITS_MASK);
        mag   = nxt[0] ? TWIST_MATRIX : 32'h0;
        return mag ^ (mixed >> 1);
    endfunction

endpackage

@@ hdl/mt19937_ram.sv @@
// State word store: one write port and two registered read ports.
// Depends on nothing but its parameters.
module mt19937_ram #(
    parameter int DEPTH  = 624,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [DATA_W-1:0] rd_data_a,
    output logic [DATA_W-1:0] rd_data_b,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Two read ports with registered data.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

@@ hdl/mt19937_out_fifo.sv @@
// Small result queue between the generator pipeline and the output channel.
// Depends on mt19937_pkg for its depth and pointer widths.
module mt19937_out_fifo (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               push,
    input  logic [mt19937_pkg::M_TDATA_W-1:0]  push_data,
    output logic [mt19937_pkg::FIFO_CNT_W-1:0] level,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mt19937_pkg::M_TDATA_W-1:0]  m_tdata
);
    import mt19937_pkg::*;

    logic [M_TDATA_W-1:0]  slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic                  pop;

    // Pop when the consumer takes the head item.
    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = slot_reg[rd_ptr_reg];
    assign level    = count_reg;

    // Pointer and fill level updates.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload slots need no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hdl/mt19937_core.sv @@
// Control and twist datapath: seed loading, read address generation, recurrence and tempering.
// Depends on mt19937_pkg; drives the state store and the result queue.
module mt19937_core #(
    parameter int STATE_WORDS = 624,
    parameter int ADDR_W      = 10
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [mt19937_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [0:0]                         s_tuser,
    input  logic [mt19937_pkg::FIFO_CNT_W-1:0] fifo_level,
    output logic                               push,
    output logic [mt19937_pkg::M_TDATA_W-1:0]  push_data,
    output logic                               rd_en,
    output logic [ADDR_W-1:0]                  rd_addr_a,
    output logic [ADDR_W-1:0]                  rd_addr_b,
    input  logic [mt19937_pkg::WORD_W-1:0]     rd_data_a,
    input  logic [mt19937_pkg::WORD_W-1:0]     rd_data_b,
    output logic                               wr_en,
    output logic [ADDR_W-1:0]                  wr_addr,
    output logic [mt19937_pkg::WORD_W-1:0]     wr_data
);
    import mt19937_pkg::*;

    localparam int CNT_W = $clog2(STATE_WORDS + 1);

    logic              accept;
    mode_t             mode;
    logic [IDX_W-1:0]  seed_index;
    logic [WORD_W-1:0] seed_word;
    logic              is_restart;
    logic              load_ok;
    logic              gen_ok;

    logic [ADDR_W-1:0] k_addr;
    logic [ADDR_W-1:0] k1_addr;
    logic [ADDR_W:0]   km_sum;
    logic [ADDR_W-1:0] km_addr;

    logic [ADDR_W-1:0] position_reg;
    logic [ADDR_W-1:0] position_next;
    logic [CNT_W-1:0]  loaded_reg;
    logic [CNT_W-1:0]  loaded_next;
    logic [WORD_W-1:0] cur_reg;
    logic [WORD_W-1:0] cur_next;

    // Second stage: a seed write or a generate step waiting for its read data.
    logic              s1_load_reg;
    logic              s1_gen_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [WORD_W-1:0] s1_word_reg;

    // Unpack the input item.
    assign mode       = mode_t'(s_tuser[0]);
    assign seed_index = s_tdata[IDX_LSB +: IDX_W];
    assign seed_word  = s_tdata[WORD_LSB +: WORD_W];

    // Accept while the queue has room for every result still in flight.
    assign s_tready = (32'(fifo_level) + 32'(s1_gen_reg)) < FIFO_DEPTH;
    assign accept   = s_tvalid && s_tready;

    // Classify the item.
    assign is_restart = (mode == MODE_LOAD) && (seed_index == '0);
    assign load_ok    = (mode == MODE_LOAD) &&
                        (is_restart ||
                         ((32'(seed_index) < STATE_WORDS) &&
                          (32'(seed_index) == 32'(loaded_reg))));
    assign gen_ok     = (mode == MODE_GEN) && (32'(loaded_reg) == STATE_WORDS);

    // Circular addresses of the next word and of the word TWIST_OFFSET ahead.
    assign k_addr  = position_reg;
    assign k1_addr = (32'(k_addr) == STATE_WORDS - 1) ? '0 : k_addr + 1'b1;
    assign km_sum  = {1'b0, k_addr} + (ADDR_W + 1)'(TWIST_OFFSET);
    assign km_addr = (32'(km_sum) >= STATE_WORDS) ?
                     ADDR_W'(km_sum - (ADDR_W + 1)'(STATE_WORDS)) : km_sum[ADDR_W-1:0];

    // Reads for a generate step are issued at accept.
    assign rd_en     = accept && gen_ok;
    assign rd_addr_a = k1_addr;
    assign rd_addr_b = km_addr;

    // Store write and result push from the second stage.
    always_comb begin
        wr_en     = s1_load_reg || s1_gen_reg;
        wr_addr   = s1_addr_reg;
        wr_data   = s1_gen_reg ? (rd_data_b ^ twist_word(cur_reg, rd_data_a)) : s1_word_reg;
        push      = s1_gen_reg;
        push_data = temper_word(cur_reg);
    end

    // Next-state logic for position, load count and the current word.
    always_comb begin
        position_next = position_reg;
        loaded_next   = loaded_reg;
        cur_next      = cur_reg;
        // A generate step hands its next word on as the following current word.
        if (s1_gen_reg) begin
            cur_next = rd_data_a;
        end
        if (accept && load_ok) begin
            if (is_restart) begin
                loaded_next   = CNT_W'(1);
                position_next = '0;
                cur_next      = seed_word;
            end else begin
                loaded_next = loaded_reg + 1'b1;
            end
        end else if (accept && gen_ok) begin
            position_next = k1_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
            loaded_reg   <= '0;
            s1_load_reg  <= 1'b0;
            s1_gen_reg   <= 1'b0;
        end else begin
            position_reg <= position_next;
            loaded_reg   <= loaded_next;
            s1_load_reg  <= accept && load_ok;
            s1_gen_reg   <= accept && gen_ok;
        end
    end

    // Payload registers of the second stage and the current word.
    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (accept) begin
            s1_addr_reg <= load_ok ? ADDR_W'(seed_index) : k_addr;
            s1_word_reg <= seed_word;
        end
    end

endmodule

@@ hdl/mt19937_stream_generator.sv @@
// Top level of the MT19937 stream generator: core, state store and result queue.
// Depends on mt19937_pkg, mt19937_core, mt19937_ram and mt19937_out_fifo.
//
//  Channel  Direction  Ports                       Item
//  s_       in         tvalid tready tdata tuser   seed load or word request
//  m_       out        tvalid tready tdata         tempered random word
//
// One item is accepted per cycle while s_tready is high.
// Each request reads two state words through the store's two read ports and writes one
// back through its write port, so the store sustains one word per cycle.
// Reset clears position and load count; the state store is not cleared, all 624 seed
// words must be loaded before requests give results.
// When the output stalls, a four-entry result queue absorbs words in flight and s_tready
// drops once it is about to fill.
module mt19937_stream_generator #(
    parameter int STATE_WORDS = 624
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata fields, lowest bit up: seed_index[9:0], seed_word[41:10], zero fill [47:42]
    input  logic [mt19937_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser fields, lowest bit up: mode[0]
    input  logic [0:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata fields, lowest bit up: random_value[31:0]
    output logic [mt19937_pkg::M_TDATA_W-1:0]  m_tdata
);
    import mt19937_pkg::*;

    localparam int ADDR_W = $clog2(STATE_WORDS);

    logic [FIFO_CNT_W-1:0] fifo_level;
    logic                  push;
    logic [M_TDATA_W-1:0]  push_data;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr_a;
    logic [ADDR_W-1:0]     rd_addr_b;
    logic [WORD_W-1:0]     rd_data_a;
    logic [WORD_W-1:0]     rd_data_b;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [WORD_W-1:0]     wr_data;

    // Loading control and recurrence datapath.
    mt19937_core #(
        .STATE_WORDS (STATE_WORDS),
        .ADDR_W      (ADDR_W)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .fifo_level (fifo_level),
        .push       (push),
        .push_data  (push_data),
        .rd_en      (rd_en),
        .rd_addr_a  (rd_addr_a),
        .rd_addr_b  (rd_addr_b),
        .rd_data_a  (rd_data_a),
        .rd_data_b  (rd_data_b),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    // Circular store of state words.
    mt19937_ram #(
        .DEPTH  (STATE_WORDS),
        .ADDR_W (ADDR_W),
        .DATA_W (WORD_W)
    ) u_ram (
        .aclk      (aclk),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    // Result queue feeding the output channel.
    mt19937_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .level     (fifo_level),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
